>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the tilt controller rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/tgmc_pkg.sv
// ----------------------------------------------------------------------------
// tgmc_pkg
// shared types and constants for the tilt gesture motor controller
// ----------------------------------------------------------------------------
package tgmc_pkg;

    localparam int CordicSteps = 16;
    localparam int IterW       = $clog2(CordicSteps + 1);
    localparam int VecW        = 20;
    localparam int AngW        = 26;
    localparam int AngleLimit  = 46080;
    localparam int QDepth      = 2;

    localparam logic [4:0] REG_PITCH_OFS = 5'd0;
    localparam logic [4:0] REG_ROLL_OFS  = 5'd1;
    localparam logic [4:0] REG_FWD_TH    = 5'd2;
    localparam logic [4:0] REG_BWD_TH    = 5'd3;
    localparam logic [4:0] REG_TURN_TH   = 5'd4;
    localparam logic [4:0] REG_MAX_SPD   = 5'd5;
    localparam logic [4:0] REG_MIN_SPD   = 5'd6;
    localparam logic [4:0] REG_RAMP      = 5'd7;

    localparam logic [2:0] CMD_STOP_RAMP = 3'd0;
    localparam logic [2:0] CMD_FWD       = 3'd1;
    localparam logic [2:0] CMD_BACK      = 3'd2;
    localparam logic [2:0] CMD_RIGHT     = 3'd3;
    localparam logic [2:0] CMD_LEFT      = 3'd4;
    localparam logic [2:0] CMD_BUTTON    = 3'd5;
    localparam logic [2:0] CMD_FAULT     = 3'd6;

    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PITCH,
        ST_ROLL,
        ST_FILT_P,
        ST_FILT_R,
        ST_DECIDE,
        ST_OUT
    } back_state_t;

    // classified sample travelling from the front part to the back part
    typedef struct packed {
        logic               halt;
        logic               pressed;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } item_t;

    typedef struct packed {
        logic signed [16:0] pitch_ofs;
        logic signed [16:0] roll_ofs;
        logic        [15:0] fwd_th;
        logic signed [16:0] bwd_th;
        logic        [15:0] turn_th;
        logic        [7:0]  max_spd;
        logic        [7:0]  min_spd;
        logic        [7:0]  ramp;
    } cfg_t;

    function automatic logic signed [AngW-1:0] atan_entry(input logic [IterW-1:0] i);
        logic signed [AngW-1:0] v;
        case (i)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [16:0] clamp_angle(input logic signed [27:0] v);
        logic signed [16:0] r;
        if (v > 28'sd46080) r = 17'sd46080;
        else if (v < -28'sd46080) r = -17'sd46080;
        else r = v[16:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/tilt_gesture_motor_controller.sv
// flow: each tilt sample beat runs two 16-step cordic passes on one shared unit,
// pitch then roll, each with its filter state, then decide, then output until taken;
// a button stop or sensor fault goes straight to output; one sample runs at a time
// a two-entry queue lets the input side take beats while a result waits
// reset: asynchronous active low; filters and duty clear, registers to defaults
// ----------------------------------------------------------------------------
// tilt_gesture_motor_controller
// accelerometer tilt to motor direction and ramped duty
// ----------------------------------------------------------------------------
module tilt_gesture_motor_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // accel_x, accel_y, accel_z
    input  logic [1:0]  s_axis_tuser,  // stop_pressed, read_ok
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // left_dir, right_dir, motor_duty, command,
                                       // pitch_filtered, roll_filtered, zero pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    tgmc_pkg::cfg_t  cfg_reg;
    tgmc_pkg::item_t q_item;
    logic            q_valid, q_pop;
    logic [1:0]      ld, rd;
    logic [7:0]      duty;
    logic [2:0]      cmd;
    logic signed [16:0] pf, rf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pitch_ofs <= '0;
            cfg_reg.roll_ofs  <= '0;
            cfg_reg.fwd_th    <= 16'd2560;
            cfg_reg.bwd_th    <= -17'sd2560;
            cfg_reg.turn_th   <= 16'd2560;
            cfg_reg.max_spd   <= 8'd150;
            cfg_reg.min_spd   <= 8'd50;
            cfg_reg.ramp      <= 8'd10;
        end
        else if (cfg_we)
        begin
            case ({2'b00, cfg_index})
                tgmc_pkg::REG_PITCH_OFS: cfg_reg.pitch_ofs <= cfg_data;
                tgmc_pkg::REG_ROLL_OFS:  cfg_reg.roll_ofs  <= cfg_data;
                tgmc_pkg::REG_FWD_TH:    cfg_reg.fwd_th    <= cfg_data[15:0];
                tgmc_pkg::REG_BWD_TH:    cfg_reg.bwd_th    <= cfg_data;
                tgmc_pkg::REG_TURN_TH:   cfg_reg.turn_th   <= cfg_data[15:0];
                tgmc_pkg::REG_MAX_SPD:   cfg_reg.max_spd   <= cfg_data[7:0];
                tgmc_pkg::REG_MIN_SPD:   cfg_reg.min_spd   <= cfg_data[7:0];
                tgmc_pkg::REG_RAMP:      cfg_reg.ramp      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tgmc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .ax       (s_axis_tdata[15:0]),
        .ay       (s_axis_tdata[31:16]),
        .az       (s_axis_tdata[47:32]),
        .pressed  (s_axis_tuser[0]),
        .ok       (s_axis_tuser[1]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    tgmc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (q_item),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .left_dir       (ld),
        .right_dir      (rd),
        .motor_duty     (duty),
        .command        (cmd),
        .pitch_filtered (pf),
        .roll_filtered  (rf)
    );

    assign m_axis_tdata = {7'b0000000, rf, pf, cmd, duty, rd, ld};

endmodule

>>> hw/rtl/tgmc_cordic.sv
// ----------------------------------------------------------------------------
// tgmc_cordic
// iterative vectoring cordic, atan2(num, den) in q8.8 degrees, one step a cycle
// ----------------------------------------------------------------------------
module tgmc_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] num,
    input  logic signed [15:0] den,
    output logic               done,
    output logic signed [16:0] angle
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic        [tgmc_pkg::IterW-1:0]   it_reg, it_next;
    logic                                zero_reg, zero_next;
    logic signed [tgmc_pkg::VecW-1:0]    x_reg, x_next, y_reg, y_next;
    logic signed [tgmc_pkg::AngW-1:0]    a_reg, a_next;
    logic signed [tgmc_pkg::VecW-1:0]    xs, ys;
    logic signed [tgmc_pkg::AngW-1:0]    rnd;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        it_next   = it_reg;
        zero_next = zero_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        a_next    = a_reg;
        xs        = x_reg >>> it_reg;
        ys        = y_reg >>> it_reg;
        if (start)
        begin
            busy_next = 1'b1;
            it_next   = '0;
            zero_next = (num == 16'sd0) && (den == 16'sd0);
            x_next    = tgmc_pkg::VecW'(den);
            y_next    = tgmc_pkg::VecW'(num);
            a_next    = '0;
            // pre-rotate into the right half plane
            if (den < 0)
            begin
                if (num >= 0)
                begin
                    x_next = tgmc_pkg::VecW'(num);
                    y_next = -tgmc_pkg::VecW'(den);
                    a_next = 26'sd5898240;
                end
                else
                begin
                    x_next = -tgmc_pkg::VecW'(num);
                    y_next = tgmc_pkg::VecW'(den);
                    a_next = -26'sd5898240;
                end
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                a_next = a_reg + tgmc_pkg::atan_entry(it_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                a_next = a_reg - tgmc_pkg::atan_entry(it_reg);
            end
            it_next = it_reg + 1'b1;
            if (it_reg == tgmc_pkg::IterW'(tgmc_pkg::CordicSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        a_reg    <= a_next;
    end

    assign rnd   = (a_reg + 26'sd128) >>> 8;
    assign done  = done_reg;
    assign angle = zero_reg ? 17'sd0 : tgmc_pkg::clamp_angle(28'(rnd));

endmodule

>>> hw/rtl/tgmc_front.sv
// ----------------------------------------------------------------------------
// tgmc_front
// accepts sample beats, classifies stop and fault, queues them for the back end
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgmc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  ax,
    input  logic signed [15:0]  ay,
    input  logic signed [15:0]  az,
    input  logic                pressed,
    input  logic                ok,
    output logic                q_valid,
    input  logic                q_pop,
    output tgmc_pkg::item_t     q_item
);

    tgmc_pkg::item_t mem [tgmc_pkg::QDepth];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    tgmc_pkg::item_t item;

    assign in_ready = (cnt_reg != 2'(tgmc_pkg::QDepth));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem[rp_reg];

    always_comb
    begin
        item.halt    = pressed || !ok;
        item.pressed = pressed;
        item.ax      = ax;
        item.ay      = ay;
        item.az      = az;
        cnt_next     = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (q_pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_pop, q_valid)
    `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= 2'(tgmc_pkg::QDepth))

endmodule

>>> hw/rtl/tgmc_back.sv
// ----------------------------------------------------------------------------
// tgmc_back
// runs both atan2 passes, filters, picks the command and ramps the duty; halts zero it
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgmc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tgmc_pkg::cfg_t     cfg,
    input  logic               q_valid,
    output logic               q_pop,
    input  tgmc_pkg::item_t    q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         left_dir,
    output logic [1:0]         right_dir,
    output logic [7:0]         motor_duty,
    output logic [2:0]         command,
    output logic signed [16:0] pitch_filtered,
    output logic signed [16:0] roll_filtered
);

    tgmc_pkg::back_state_t state_reg, state_next;
    logic        [7:0]  duty_reg, duty_next;
    logic signed [31:0] ps_reg, ps_next, rs_reg, rs_next;
    logic signed [16:0] samp_reg, samp_next;
    logic        [1:0]  ld_reg, ld_next, rd_reg, rd_next;
    logic        [2:0]  cmd_reg, cmd_next;
    logic               cstart;
    logic signed [15:0] cnum;
    logic               cdone;
    logic signed [16:0] cang;
    logic signed [17:0] diff;
    logic signed [31:0] fold, fnew;
    logic signed [47:0] acc;
    logic signed [16:0] pf, rf, apf, arf;
    logic signed [17:0] fwd_s, turn_s;
    logic        [7:0]  target;
    logic        [8:0]  up;

    tgmc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cstart),
        .num   (cnum),
        .den   (q_item.az),
        .done  (cdone),
        .angle (cang)
    );

    function automatic logic signed [16:0] filt_out(input logic signed [31:0] s);
        logic signed [31:0] t;
        t = (s + 32'sd128) >>> 8;
        return tgmc_pkg::clamp_angle(28'(t));
    endfunction

    assign pf     = filt_out(ps_reg);
    assign rf     = filt_out(rs_reg);
    assign apf    = pf[16] ? -pf : pf;
    assign arf    = rf[16] ? -rf : rf;
    assign up     = {1'b0, duty_reg} + {1'b0, cfg.ramp};
    // thresholds as signed so negative angles compare correctly
    assign fwd_s  = $signed({2'b00, cfg.fwd_th});
    assign turn_s = $signed({2'b00, cfg.turn_th});

    always_comb
    begin
        state_next = state_reg;
        duty_next  = duty_reg;
        ps_next    = ps_reg;
        rs_next    = rs_reg;
        samp_next  = samp_reg;
        ld_next    = ld_reg;
        rd_next    = rd_reg;
        cmd_next   = cmd_reg;
        cstart     = 1'b0;
        cnum       = q_item.ay;
        q_pop      = 1'b0;
        out_valid  = 1'b0;
        diff       = '0;
        fold       = ps_reg;
        target     = cfg.min_spd;
        case (state_reg)
            tgmc_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.halt)
                    begin
                        duty_next  = '0;
                        ld_next    = tgmc_pkg::DIR_OFF;
                        rd_next    = tgmc_pkg::DIR_OFF;
                        cmd_next   = q_item.pressed ? tgmc_pkg::CMD_BUTTON
                                                    : tgmc_pkg::CMD_FAULT;
                        state_next = tgmc_pkg::ST_OUT;
                    end
                    else
                    begin
                        cstart     = 1'b1;
                        state_next = tgmc_pkg::ST_PITCH;
                    end
                end
            end
            tgmc_pkg::ST_PITCH:
            begin
                if (cdone)
                begin
                    diff       = 18'(cang) - 18'(cfg.pitch_ofs);
                    samp_next  = tgmc_pkg::clamp_angle(28'(diff));
                    cnum       = q_item.ax;
                    cstart     = 1'b1;
                    state_next = tgmc_pkg::ST_FILT_P;
                end
            end
            tgmc_pkg::ST_FILT_P:
            begin
                fold       = ps_reg;
                ps_next    = fnew;
                state_next = tgmc_pkg::ST_ROLL;
            end
            tgmc_pkg::ST_ROLL:
            begin
                if (cdone)
                begin
                    diff       = 18'(cang) - 18'(cfg.roll_ofs);
                    samp_next  = tgmc_pkg::clamp_angle(28'(diff));
                    state_next = tgmc_pkg::ST_FILT_R;
                end
            end
            tgmc_pkg::ST_FILT_R:
            begin
                fold       = rs_reg;
                rs_next    = fnew;
                state_next = tgmc_pkg::ST_DECIDE;
            end
            tgmc_pkg::ST_DECIDE:
            begin
                if ((18'(apf) > fwd_s) || (18'(arf) > turn_s))
                    target = cfg.max_spd;
                ld_next  = tgmc_pkg::DIR_OFF;
                rd_next  = tgmc_pkg::DIR_OFF;
                cmd_next = tgmc_pkg::CMD_STOP_RAMP;
                if (18'(pf) > fwd_s)
                begin
                    cmd_next = tgmc_pkg::CMD_FWD;
                    ld_next  = tgmc_pkg::DIR_FWD;
                    rd_next  = tgmc_pkg::DIR_FWD;
                end
                else if (pf < cfg.bwd_th)
                begin
                    cmd_next = tgmc_pkg::CMD_BACK;
                    ld_next  = tgmc_pkg::DIR_REV;
                    rd_next  = tgmc_pkg::DIR_REV;
                end
                else if (18'(rf) > turn_s)
                begin
                    cmd_next = tgmc_pkg::CMD_RIGHT;
                    ld_next  = tgmc_pkg::DIR_FWD;
                    rd_next  = tgmc_pkg::DIR_REV;
                end
                else if (18'(rf) < -turn_s)
                begin
                    cmd_next = tgmc_pkg::CMD_LEFT;
                    ld_next  = tgmc_pkg::DIR_REV;
                    rd_next  = tgmc_pkg::DIR_FWD;
                end
                if (cmd_next == tgmc_pkg::CMD_STOP_RAMP)
                    duty_next = (duty_reg > cfg.ramp) ? duty_reg - cfg.ramp : 8'd0;
                else if (duty_reg < target)
                    duty_next = (up < {1'b0, target}) ? up[7:0] : target;
                state_next = tgmc_pkg::ST_OUT;
            end
            tgmc_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    q_pop      = 1'b1;
                    state_next = tgmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tgmc_pkg::ST_IDLE;
            end
        endcase
    end

    // q16 low-pass: (6554*sample*256 + 58982*old + 2^15) >> 16
    assign acc  = 48'sd1677824 * 48'(samp_reg) + 48'sd58982 * 48'(fold) + 48'sd32768;
    assign fnew = 32'(acc >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgmc_pkg::ST_IDLE;
            duty_reg  <= '0;
            ps_reg    <= '0;
            rs_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            duty_reg  <= duty_next;
            ps_reg    <= ps_next;
            rs_reg    <= rs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        ld_reg   <= ld_next;
        rd_reg   <= rd_next;
        cmd_reg  <= cmd_next;
    end

    assign left_dir       = ld_reg;
    assign right_dir      = rd_reg;
    assign motor_duty     = duty_reg;
    assign command        = cmd_reg;
    assign pitch_filtered = pf;
    assign roll_filtered  = rf;

    `ASSERT_IMPL(a_halt_zero, clk, rst_n,
        out_valid && (cmd_reg == tgmc_pkg::CMD_BUTTON || cmd_reg == tgmc_pkg::CMD_FAULT),
        duty_reg == 8'd0)
    `ASSERT_NEXT(a_pop_idle, clk, rst_n, q_pop, state_reg == tgmc_pkg::ST_IDLE)

endmodule

>>> tb/tilt_gesture_motor_controller_tb.sv
// ----------------------------------------------------------------------------
// tilt_gesture_motor_controller_tb
// drives accelerometer samples through the controller and checks every result
// beat against an in-bench model of the cordic angles, the tilt filters and
// the duty ramp, across several register settings and handshake idle mixes
// ----------------------------------------------------------------------------
module tilt_gesture_motor_controller_tb;

    typedef struct {
        logic [1:0]  left_dir;
        logic [1:0]  right_dir;
        logic [7:0]  duty;
        logic [2:0]  cmd;
        logic [16:0] pitch;
        logic [16:0] roll;
    } drive_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    // bench copy of the registers and the controller state
    longint pitch_ofs, roll_ofs, fwd_th, bwd_th, turn_th;
    int     max_spd, min_spd, ramp;
    int     duty_level;
    longint pitch_acc, roll_acc;

    drive_t expected_drive[$];
    int     sender_idle;
    int     receiver_idle;
    int     errors;
    int     samples_sent;
    int     beats_checked;
    int     halts_sent;

    tilt_gesture_motor_controller uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint clamp_deg(input longint v);
        if (v > tgmc_pkg::AngleLimit) return tgmc_pkg::AngleLimit;
        if (v < -tgmc_pkg::AngleLimit) return -tgmc_pkg::AngleLimit;
        return v;
    endfunction

    function automatic longint atan_step(input int i);
        longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    // vectoring cordic, result in q8.8 degrees
    function automatic longint tilt_angle(input longint num, input longint den);
        longint vx, vy, ang, t;
        vx = den;
        vy = num;
        ang = 0;
        if (num == 0 && den == 0)
            return 0;
        if (den < 0)
        begin
            if (num >= 0)
            begin
                vx = num; vy = -den; ang = 90 * 65536;
            end
            else
            begin
                vx = -num; vy = den; ang = -90 * 65536;
            end
        end
        for (int i = 0; i < tgmc_pkg::CordicSteps && i < 24; i++)
        begin
            t = vx;
            if (vy > 0)
            begin
                vx = vx + (vy >>> i);
                vy = vy - (t >>> i);
                ang += atan_step(i);
            end
            else
            begin
                vx = vx - (vy >>> i);
                vy = vy + (t >>> i);
                ang -= atan_step(i);
            end
        end
        return clamp_deg((ang + 128) >>> 8);
    endfunction

    function automatic longint smooth(input longint old, input longint sample);
        return (6554 * sample * 256 + 58982 * old + 32768) >>> 16;
    endfunction

    task automatic predict_drive(input logic [15:0] ax, input logic [15:0] ay,
                                 input logic [15:0] az, input logic pressed,
                                 input logic ok);
        drive_t d;
        longint p, r, pf, rf, apf, arf;
        int     target;
        d.left_dir  = tgmc_pkg::DIR_OFF;
        d.right_dir = tgmc_pkg::DIR_OFF;
        if (pressed || !ok)
        begin
            duty_level = 0;
            d.cmd = pressed ? tgmc_pkg::CMD_BUTTON : tgmc_pkg::CMD_FAULT;
            halts_sent++;
        end
        else
        begin
            p = clamp_deg(tilt_angle(longint'($signed(ay)), longint'($signed(az))) - pitch_ofs);
            r = clamp_deg(tilt_angle(longint'($signed(ax)), longint'($signed(az))) - roll_ofs);
            pitch_acc = smooth(pitch_acc, p);
            roll_acc  = smooth(roll_acc, r);
            pf = clamp_deg((pitch_acc + 128) >>> 8);
            rf = clamp_deg((roll_acc + 128) >>> 8);
            apf = pf < 0 ? -pf : pf;
            arf = rf < 0 ? -rf : rf;
            target = (apf > fwd_th || arf > turn_th) ? max_spd : min_spd;
            if (pf > fwd_th)
            begin
                d.cmd = tgmc_pkg::CMD_FWD;
                d.left_dir = tgmc_pkg::DIR_FWD;
                d.right_dir = tgmc_pkg::DIR_FWD;
            end
            else if (pf < bwd_th)
            begin
                d.cmd = tgmc_pkg::CMD_BACK;
                d.left_dir = tgmc_pkg::DIR_REV;
                d.right_dir = tgmc_pkg::DIR_REV;
            end
            else if (rf > turn_th)
            begin
                d.cmd = tgmc_pkg::CMD_RIGHT;
                d.left_dir = tgmc_pkg::DIR_FWD;
                d.right_dir = tgmc_pkg::DIR_REV;
            end
            else if (rf < -turn_th)
            begin
                d.cmd = tgmc_pkg::CMD_LEFT;
                d.left_dir = tgmc_pkg::DIR_REV;
                d.right_dir = tgmc_pkg::DIR_FWD;
            end
            else
                d.cmd = tgmc_pkg::CMD_STOP_RAMP;
            if (d.cmd == tgmc_pkg::CMD_STOP_RAMP)
                duty_level = (duty_level > ramp) ? duty_level - ramp : 0;
            else if (duty_level < target)
                duty_level = (duty_level + ramp < target) ? duty_level + ramp : target;
        end
        d.duty  = duty_level[7:0];
        d.pitch = 17'(clamp_deg((pitch_acc + 128) >>> 8));
        d.roll  = 17'(clamp_deg((roll_acc + 128) >>> 8));
        expected_drive.push_back(d);
    endtask

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            drive_t d;
            if (expected_drive.size() == 0)
                report("unexpected beat", m_axis_tdata, 0);
            else
            begin
                d = expected_drive.pop_front();
                beats_checked++;
                if (m_axis_tdata[1:0] !== d.left_dir)   report("left_dir", m_axis_tdata[1:0], d.left_dir);
                if (m_axis_tdata[3:2] !== d.right_dir)  report("right_dir", m_axis_tdata[3:2], d.right_dir);
                if (m_axis_tdata[11:4] !== d.duty)      report("motor_duty", m_axis_tdata[11:4], d.duty);
                if (m_axis_tdata[14:12] !== d.cmd)      report("command", m_axis_tdata[14:12], d.cmd);
                if (m_axis_tdata[31:15] !== d.pitch)
                    report("pitch_filtered", m_axis_tdata[31:15], d.pitch);
                if (m_axis_tdata[48:32] !== d.roll)
                    report("roll_filtered", m_axis_tdata[48:32], d.roll);
            end
        end
    end

    // sink side backpressure
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle);

    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic pressed, input logic ok);
        while ($urandom_range(0, 99) < sender_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {az, ay, ax};
        s_axis_tuser  = {ok, pressed};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_drive(ax, ay, az, pressed, ok);
        samples_sent++;
        @(negedge clk);
    endtask

    // lower valid, let every result drain and the block go quiet
    task automatic drain;
        s_axis_tvalid = 1'b0;
        while (expected_drive.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = 17'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            tgmc_pkg::REG_PITCH_OFS[2:0]: pitch_ofs = longint'($signed(17'(value)));
            tgmc_pkg::REG_ROLL_OFS[2:0]:  roll_ofs  = longint'($signed(17'(value)));
            tgmc_pkg::REG_FWD_TH[2:0]:    fwd_th    = value & 16'hffff;
            tgmc_pkg::REG_BWD_TH[2:0]:    bwd_th    = longint'($signed(17'(value)));
            tgmc_pkg::REG_TURN_TH[2:0]:   turn_th   = value & 16'hffff;
            tgmc_pkg::REG_MAX_SPD[2:0]:   max_spd   = int'(value & 8'hff);
            tgmc_pkg::REG_MIN_SPD[2:0]:   min_spd   = int'(value & 8'hff);
            default:                      ramp      = int'(value & 8'hff);
        endcase
    endtask

    task automatic load_settings(input longint po, input longint ro, input longint ft,
                                 input longint bt, input longint tt, input int mx,
                                 input int mn, input int rs);
        drain();
        write_reg(tgmc_pkg::REG_PITCH_OFS[2:0], po);
        write_reg(tgmc_pkg::REG_ROLL_OFS[2:0], ro);
        write_reg(tgmc_pkg::REG_FWD_TH[2:0], ft);
        write_reg(tgmc_pkg::REG_BWD_TH[2:0], bt);
        write_reg(tgmc_pkg::REG_TURN_TH[2:0], tt);
        write_reg(tgmc_pkg::REG_MAX_SPD[2:0], mx);
        write_reg(tgmc_pkg::REG_MIN_SPD[2:0], mn);
        write_reg(tgmc_pkg::REG_RAMP[2:0], rs);
    endtask

    task automatic random_settings;
        load_settings($urandom_range(0, 2 * 2560) - 2560, $urandom_range(0, 2 * 2560) - 2560,
                      $urandom_range(256, 6000), -longint'($urandom_range(256, 6000)),
                      $urandom_range(256, 6000), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(1, 255));
    endtask

    task automatic test_directed_samples;
        send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);   // zero vector
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b1);
        send_sample(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b1);
        send_sample(16'h0000, 16'h4000, 16'hc000, 1'b0, 1'b1);   // z negative, y up
        send_sample(16'hc000, 16'hc000, 16'hc000, 1'b0, 1'b1);   // z negative, y down
        send_sample(16'h7fff, 16'h8000, 16'h0000, 1'b0, 1'b1);   // z zero
        send_sample(16'h1234, 16'h5678, 16'h0100, 1'b1, 1'b1);   // button
        send_sample(16'h1234, 16'h5678, 16'h0100, 1'b0, 1'b0);   // sensor fault
        send_sample(16'h1234, 16'h5678, 16'h0100, 1'b1, 1'b0);   // both, button wins
        repeat (5) send_sample(16'h0000, 16'h7000, 16'h1000, 1'b0, 1'b1);   // forward
        repeat (6) send_sample(16'h0000, 16'h9000, 16'h1000, 1'b0, 1'b1);   // backward
        repeat (3) send_sample(16'h0000, 16'h0000, 16'h4000, 1'b0, 1'b1);   // level
        drain();
        load_settings(0, 0, 2560, -2560, 2560, 150, 50, 10);
        pitch_acc = pitch_acc; // filters carry over
        repeat (4) send_sample(16'h7000, 16'h0000, 16'h1000, 1'b0, 1'b1);   // right
        repeat (4) send_sample(16'h9000, 16'h0000, 16'h1000, 1'b0, 1'b1);   // left
    endtask

    task automatic test_register_extremes;
        // offsets at the limits push the corrected angle into saturation
        load_settings(46080, -46080, 0, 0, 0, 255, 0, 255);
        repeat (8) send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b1);
        load_settings(-46080, 46080, 46080, -46080, 46080, 0, 255, 1);
        repeat (8) send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b1);
        // zero ramp step holds the duty; crossed thresholds
        load_settings(0, 0, 0, 2560, 0, 200, 100, 0);
        repeat (8) send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b1);
        load_settings(0, 0, 2560, -2560, 2560, 150, 50, 10);
    endtask

    // mostly held gestures with noisy content, some raw noise and halts
    task automatic run_gestures(input int count);
        int kind, len, sent;
        logic [15:0] ax, ay, az;
        logic pressed, ok;
        sent = 0;
        while (sent < count)
        begin
            if (sent % 110 == 109)
                random_settings();
            kind = $urandom_range(0, 5);
            len = $urandom_range(3, 15);
            for (int k = 0; k < len; k++)
            begin
                ax = 16'($signed($urandom_range(0, 2000)) - 1000);
                ay = 16'($signed($urandom_range(0, 2000)) - 1000);
                az = 16'($urandom_range(2000, 20000));
                case (kind)
                    0: ay = 16'($urandom_range(4000, 32767));
                    1: ay = 16'(-$signed($urandom_range(4000, 32768)));
                    2: ax = 16'($urandom_range(4000, 32767));
                    3: ax = 16'(-$signed($urandom_range(4000, 32768)));
                    4: ;
                    default:
                    begin
                        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
                    end
                endcase
                pressed = ($urandom_range(0, 99) < 6);
                ok = ($urandom_range(0, 99) >= 6);
                send_sample(ax, ay, az, pressed, ok);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic;
        sender_idle = 37; receiver_idle = 69;
        run_gestures(440);
        random_settings();
        sender_idle = 69; receiver_idle = 37;
        run_gestures(440);
        random_settings();
        sender_idle = 0; receiver_idle = 0;
        run_gestures(420);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 2'b10;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0; samples_sent = 0; beats_checked = 0; halts_sent = 0;
        pitch_ofs = 0; roll_ofs = 0; fwd_th = 2560; bwd_th = -2560; turn_th = 2560;
        max_spd = 150; min_spd = 50; ramp = 10;
        duty_level = 0; pitch_acc = 0; roll_acc = 0;
        sender_idle = 37; receiver_idle = 69;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_samples();
        test_register_extremes();
        test_random_traffic();

        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d samples (%0d button or fault halts), %0d result beats checked",
                 samples_sent, halts_sent, beats_checked);
        $display("register extremes, crossed thresholds and three idle mixes exercised");
        if (errors == 0 && expected_drive.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
